// ===== rtl/ipv4_ddp_pkg.sv =====
// ----------------------------------------------------------------------------
// IPv4 dotted-decimal parser package
// Character codes, result status codes and field widths shared by the parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ipv4_ddp_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned AddrW   = 32;
  localparam int unsigned OctValW = 9;   // running value, saturates at 256
  localparam int unsigned OctIdxW = 3;   // dots seen, saturates at 7
  localparam int unsigned OctLenW = 2;   // digits seen, saturates at 3

  localparam logic [CharW-1:0] CharNul   = 8'h00;
  localparam logic [CharW-1:0] CharDot   = 8'h2E;
  localparam logic [CharW-1:0] CharZero  = 8'h30;
  localparam logic [CharW-1:0] CharNine  = 8'h39;

  localparam logic [OctValW-1:0] OctMax  = 9'd255;
  localparam logic [OctValW-1:0] OctSat  = 9'd256;
  localparam logic [OctIdxW-1:0] IdxLast = 3'd3;
  localparam logic [OctIdxW-1:0] IdxSat  = 3'd7;
  localparam logic [OctLenW-1:0] LenSat  = 2'd3;

  typedef enum logic [1:0] {
    StatusOk        = 2'd0,
    StatusMalformed = 2'd1,
    StatusRange     = 2'd2
  } status_e;

endpackage

`default_nettype wire

// ===== rtl/ipv4_dotted_decimal_parser.sv =====
// ----------------------------------------------------------------------------
// IPv4 dotted-decimal parser
// Parses a NUL-terminated address string, one character per request, into a
// 32-bit address and a status code.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one ASCII character per request on char_in_i, qualified by
//   in_valid_i and held off by in_stall_o. A NUL character ends the string.
//   Output channel: one result per string (status_o, address_o), qualified by
//   out_valid_o and held off by out_stall_i. Characters other than NUL give
//   no result. address_o is zero unless status_o is ok; the first octet lands
//   in bits 7:0.
//   Throughput: one character per cycle, including back-to-back strings, while
//   no NUL waits behind a stalled result; the single combinational update
//   step between input register and state / result register sets this rate.
//   End of string: a NUL passes from the input register into the parser
//   state and the result register, which then holds its result on the output.
//   Stall: while a result waits in the output register, ordinary characters
//   keep flowing; only a second NUL waits in the input register, and then
//   in_stall_o rises until the waiting result is taken.
//   Reset: asynchronous, active low; clears the pipeline valid bits and all
//   parser state, so the first character after reset starts a new string.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_dotted_decimal_parser
  import ipv4_ddp_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // character requests
  input  wire logic [CharW-1:0] char_in_i,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  // parse results
  output logic [1:0]            status_o,
  output logic [AddrW-1:0]      address_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i
);

  // input register
  logic             in_valid_q;
  logic [CharW-1:0] char_q;

  // parser state
  logic [OctValW-1:0] oct_val_q, oct_val_d;
  logic [OctIdxW-1:0] oct_idx_q, oct_idx_d;
  logic [OctLenW-1:0] oct_len_q, oct_len_d;
  logic               starts_zero_q, starts_zero_d;
  logic               lz_seen_q, lz_seen_d;
  status_e            err_q, err_d;
  logic [AddrW-1:0]   packed_q, packed_d;

  // result register
  logic             out_valid_q;
  status_e          status_q, status_d;
  logic [AddrW-1:0] address_q, address_d;

  logic is_digit, is_dot, is_nul;
  logic consume, consume_nul, out_free;

  assign is_digit = (char_q >= CharZero) && (char_q <= CharNine);
  assign is_dot   = (char_q == CharDot);
  assign is_nul   = (char_q == CharNul);

  // A NUL needs a free result slot; everything else goes straight through.
  assign out_free    = !out_valid_q || !out_stall_i;
  assign consume     = in_valid_q && (!is_nul || out_free);
  assign consume_nul = in_valid_q && is_nul && out_free;
  assign in_stall_o  = in_valid_q && !consume;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      char_q <= char_in_i;
    end
  end

  // --------------------------------------------------------------------------
  // Single update step: digit accumulate, octet close, end of string, error on other characters.
  // --------------------------------------------------------------------------
  logic [11:0]        mul_sum;
  logic [OctValW-1:0] digit_val;
  logic               close_err_rng;
  logic               close_lz;
  logic [AddrW-1:0]   packed_closed;
  logic [4:0]         byte_sh;
  status_e            err_closed;
  logic               lz_closed;
  status_e            fin_status;

  assign digit_val = {1'b0, char_q - CharZero};
  // v * 10 = (v << 3) + (v << 1); at most 2569, fits in 12 bits
  assign mul_sum   = {oct_val_q, 3'b000} + {2'b00, oct_val_q, 1'b0} + {3'b000, digit_val};

  assign close_err_rng = (oct_val_q > OctMax);
  assign close_lz      = starts_zero_q && (oct_len_q >= 2'd2);
  assign byte_sh       = {oct_idx_q[1:0], 3'b000};

  always_comb begin
    packed_closed = packed_q;
    if (!oct_idx_q[2]) begin
      packed_closed = (packed_q & ~({{(AddrW-8){1'b0}}, 8'hFF} << byte_sh))
                    | ({{(AddrW-8){1'b0}}, oct_val_q[7:0]} << byte_sh);
    end
    err_closed = err_q;
    if (close_err_rng && (err_q == StatusOk)) begin
      err_closed = StatusRange;
    end
    lz_closed = lz_seen_q || close_lz;
    if (err_closed != StatusOk) begin
      fin_status = err_closed;
    end else if ((oct_idx_q != IdxLast) || lz_closed) begin
      fin_status = StatusMalformed;
    end else begin
      fin_status = StatusOk;
    end
  end

  always_comb begin
    oct_val_d     = oct_val_q;
    oct_idx_d     = oct_idx_q;
    oct_len_d     = oct_len_q;
    starts_zero_d = starts_zero_q;
    lz_seen_d     = lz_seen_q;
    err_d         = err_q;
    packed_d      = packed_q;
    status_d      = status_q;
    address_d     = address_q;
    if (consume) begin
      if (is_digit) begin
        if (oct_len_q == '0) begin
          starts_zero_d = (char_q == CharZero);
        end
        if (oct_len_q != LenSat) begin
          oct_len_d = oct_len_q + 2'd1;
        end
        oct_val_d = (mul_sum > 12'(OctSat)) ? OctSat : mul_sum[OctValW-1:0];
      end else if (is_dot) begin
        // close the octet, advance the index, start a fresh octet
        err_d         = err_closed;
        lz_seen_d     = lz_closed;
        packed_d      = packed_closed;
        if (oct_idx_q != IdxSat) begin
          oct_idx_d = oct_idx_q + 3'd1;
        end
        oct_val_d     = '0;
        oct_len_d     = '0;
        starts_zero_d = 1'b0;
      end else if (is_nul) begin
        // emit the result and drop all state for the next string
        status_d      = fin_status;
        address_d     = (fin_status == StatusOk) ? packed_closed : '0;
        oct_val_d     = '0;
        oct_idx_d     = '0;
        oct_len_d     = '0;
        starts_zero_d = 1'b0;
        lz_seen_d     = 1'b0;
        err_d         = StatusOk;
        packed_d      = '0;
      end else if (err_q == StatusOk) begin
        err_d = StatusMalformed;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oct_val_q     <= '0;
      oct_idx_q     <= '0;
      oct_len_q     <= '0;
      starts_zero_q <= 1'b0;
      lz_seen_q     <= 1'b0;
      err_q         <= StatusOk;
      packed_q      <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      oct_val_q     <= oct_val_d;
      oct_idx_q     <= oct_idx_d;
      oct_len_q     <= oct_len_d;
      starts_zero_q <= starts_zero_d;
      lz_seen_q     <= lz_seen_d;
      err_q         <= err_d;
      packed_q      <= packed_d;
      if (consume_nul) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    address_q <= address_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign address_o   = address_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_nul_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    consume_nul |=> out_valid_q)
    else $error("NUL absorbed without a result");

  a_nul_clears_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    consume_nul |=> (oct_idx_q == '0) && (err_q == StatusOk) && (packed_q == '0))
    else $error("state not cleared after end of string");

  a_addr_zero_on_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (status_q != StatusOk)) |-> (address_q == '0))
    else $error("nonzero address with error status");

  a_value_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oct_val_q <= OctSat)
    else $error("octet value beyond saturation");

  a_stall_needs_nul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && is_nul && out_valid_q))
    else $error("input stalled without a waiting NUL");

endmodule

`default_nettype wire
